// ----- rtl/wcs_pkg.sv -----
// wcs_pkg: shared types and constants of the windowed charge statistics unit
// no dependencies
package wcs_pkg;

  localparam int MON_W   = 16;
  localparam int TOT_W   = 20;
  localparam int STAMP_W = 32;
  localparam int RATIO_W = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MON_LOW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MON_HIGH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOT_LIMIT     = 3'd4;

  localparam logic [15:0]        RST_WINDOW_LENGTH = 16'd4500;
  localparam logic [STAMP_W-1:0] RST_START_TIME    = 32'd1594080000;
  localparam logic [MON_W-1:0]   RST_MON_LOW       = 16'd8000;
  localparam logic [MON_W-1:0]   RST_MON_HIGH      = 16'd64000;
  localparam logic [TOT_W-1:0]   RST_TOT_LIMIT     = 20'd32000;

  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
  localparam logic [MON_W-1:0]   MON_MAX   = '1;

  typedef struct packed {
    logic [MON_W-1:0]   mon;
    logic [TOT_W-1:0]   tot;
    logic [STAMP_W-1:0] stamp;
    logic               acc;
    logic               close;
  } item_t;

endpackage

// ----- rtl/wcs_queue.sv -----
// wcs_queue: four-entry item queue between front and back
// depends on wcs_pkg
module wcs_queue
  import wcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_item,
  output logic  full,
  output logic  valid,
  input  logic  rd,
  output item_t rd_item
);

  item_t       mem [4];
  logic [1:0]  head;
  logic [1:0]  tail;
  logic [2:0]  count;

  assign full    = (count == 3'd4);
  assign valid   = (count != 3'd0);
  assign rd_item = mem[head];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[tail] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        tail <= tail + 2'd1;
      end
      if (rd && valid) begin
        head <= head + 2'd1;
      end
      count <= count + 3'((wr && !full) ? 1 : 0) - 3'((rd && valid) ? 1 : 0);
    end
  end

endmodule

// ----- rtl/wcs_front.sv -----
// wcs_front: configuration registers, position tracking and sample cuts
// depends on wcs_pkg
module wcs_front
  import wcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  logic                  q_full,
  input  logic [MON_W-1:0]      mon_charge,
  input  logic [TOT_W-1:0]      total_charge,
  input  logic [STAMP_W-1:0]    stamp,
  output logic                  q_wr,
  output item_t                 q_item
);

  logic [15:0]        window_length;
  logic [STAMP_W-1:0] start_time;
  logic [MON_W-1:0]   mon_low;
  logic [MON_W-1:0]   mon_high;
  logic [TOT_W-1:0]   tot_limit;
  logic [15:0]        phase;
  logic               past_first;
  logic [16:0]        phase_inc;
  logic               pass;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;
  assign phase_inc = {1'b0, phase} + 17'd1;
  assign pass      = (mon_charge > mon_low) && (mon_charge < mon_high) && (stamp > start_time);

  assign q_wr         = accept && pass;
  assign q_item.mon   = mon_charge;
  assign q_item.tot   = total_charge;
  assign q_item.stamp = stamp;
  assign q_item.acc   = (total_charge < tot_limit);
  assign q_item.close = past_first && (phase == 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= RST_WINDOW_LENGTH;
      start_time    <= RST_START_TIME;
      mon_low       <= RST_MON_LOW;
      mon_high      <= RST_MON_HIGH;
      tot_limit     <= RST_TOT_LIMIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[15:0];
        REG_START_TIME:    start_time    <= cfg_data[STAMP_W-1:0];
        REG_MON_LOW:       mon_low       <= cfg_data[MON_W-1:0];
        REG_MON_HIGH:      mon_high      <= cfg_data[MON_W-1:0];
        REG_TOT_LIMIT:     tot_limit     <= cfg_data[TOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      past_first <= 1'b0;
    end else if (accept) begin
      phase      <= (phase_inc >= {1'b0, window_length}) ? 16'd0 : phase_inc[15:0];
      past_first <= 1'b1;
    end
  end

endmodule

// ----- rtl/wcs_back.sv -----
// wcs_back: ratio divide, accumulation, window means and spreads, result register
// depends on wcs_pkg
module wcs_back
  import wcs_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output logic [MON_W-1:0]   mean_mon,
  output logic [RATIO_W-1:0] mean_ratio,
  output logic [MON_W-1:0]   spread_mon,
  output logic [RATIO_W-1:0] spread_ratio,
  output logic [STAMP_W-1:0] close_stamp,
  output logic [15:0]        used_samples,
  output logic               empty_window
);

  localparam int CW     = COUNT_WIDTH;
  localparam int SW     = CW + RATIO_W;
  localparam int PW     = CW + 38;
  localparam int STEP_W = $clog2(SW + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RATIO  = 4'd1;
  localparam logic [3:0] ST_ACC    = 4'd2;
  localparam logic [3:0] ST_CHECK  = 4'd3;
  localparam logic [3:0] ST_DIVM   = 4'd4;
  localparam logic [3:0] ST_DIVR   = 4'd5;
  localparam logic [3:0] ST_SPREAD = 4'd6;
  localparam logic [3:0] ST_EMIT   = 4'd7;

  localparam logic [CW-1:0] COUNT_MAX = '1;

  logic [3:0]         state;
  logic [STEP_W-1:0]  step;
  logic [1:0]         sub;
  logic               sel;
  item_t              item;
  logic [RATIO_W-1:0] ratio;
  logic [15:0]        rrem;

  logic [CW+MON_W-1:0]   sum_mon;
  logic [SW-1:0]         sum_ratio;
  logic [CW-1:0]         used_count;
  logic [MON_W-1:0]      min_mon, max_mon;
  logic [RATIO_W-1:0]    min_ratio, max_ratio;

  logic [SW-1:0]      dq;
  logic [CW-1:0]      drem;
  logic [RATIO_W-1:0] q;
  logic [RATIO_W-1:0] d;
  logic [35:0]        lim;
  logic [35:0]        tt;
  logic [CW+17:0]     plo, phi;
  logic               t_ok;

  logic [MON_W-1:0]   res_mean_mon;
  logic [RATIO_W-1:0] res_mean_ratio;
  logic [MON_W-1:0]   res_spread_mon;
  logic               out_valid;

  logic               rbit;
  logic [16:0]        rrem_sh;
  logic               rge;
  logic [CW:0]        drem_sh;
  logic               dge;
  logic [SW-1:0]      dq_next;
  logic [18:0]        t;
  logic [PW-1:0]      prod;
  logic [CW+16:0]     used_ext;

  always_comb begin
    rbit    = (step == STEP_W'(17)) ? item.tot[1] : ((step == STEP_W'(16)) ? item.tot[0] : 1'b0);
    rrem_sh = {rrem, rbit};
    rge     = (rrem_sh >= {1'b0, item.mon});
    drem_sh = {drem, dq[SW-1]};
    dge     = (drem_sh >= {1'b0, used_count});
    dq_next = {dq[SW-2:0], dge};
    t       = {1'b0, q} | (19'd1 << step[4:0]);
    prod    = (PW'(phi) << 18) + PW'(plo);
    used_ext = (CW+17)'(used_count);
  end

  assign q_rd  = (state == ST_IDLE) && q_valid;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      sum_mon    <= '0;
      sum_ratio  <= '0;
      used_count <= '0;
      min_mon    <= MON_MAX;
      max_mon    <= '0;
      min_ratio  <= RATIO_MAX;
      max_ratio  <= '0;
      step       <= '0;
      sub        <= '0;
      sel        <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            item <= q_item;
            if (q_item.acc && (used_count < COUNT_MAX)) begin
              if ({2'b0, q_item.tot} >= {4'b0, q_item.mon, 2'b0}) begin
                ratio <= RATIO_MAX;
                state <= ST_ACC;
              end else begin
                rrem  <= q_item.tot[17:2];
                step  <= STEP_W'(17);
                state <= ST_RATIO;
              end
            end else begin
              state <= q_item.close ? ST_CHECK : ST_IDLE;
            end
          end
        end
        ST_RATIO: begin
          rrem  <= rge ? 16'(rrem_sh - {1'b0, item.mon}) : rrem_sh[15:0];
          ratio <= {ratio[RATIO_W-2:0], rge};
          step  <= step - STEP_W'(1);
          if (step == '0) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          sum_mon    <= sum_mon + (CW+MON_W)'(item.mon);
          sum_ratio  <= sum_ratio + SW'(ratio);
          used_count <= used_count + CW'(1);
          if (item.mon < min_mon) min_mon <= item.mon;
          if (item.mon > max_mon) max_mon <= item.mon;
          if (ratio < min_ratio) min_ratio <= ratio;
          if (ratio > max_ratio) max_ratio <= ratio;
          state <= item.close ? ST_CHECK : ST_IDLE;
        end
        ST_CHECK: begin
          if (used_count == '0) begin
            state <= ST_EMIT;
          end else begin
            dq    <= SW'(sum_mon);
            drem  <= '0;
            step  <= STEP_W'(SW - 1);
            state <= ST_DIVM;
          end
        end
        ST_DIVM, ST_DIVR: begin
          if (step == '0) begin
            drem <= '0;
            if (state == ST_DIVM) begin
              res_mean_mon <= dq_next[MON_W-1:0];
              dq           <= sum_ratio;
              step         <= STEP_W'(SW - 1);
              state        <= ST_DIVR;
            end else begin
              res_mean_ratio <= dq_next[RATIO_W-1:0];
              d     <= RATIO_W'(max_mon - min_mon);
              q     <= '0;
              sel   <= 1'b0;
              sub   <= '0;
              step  <= STEP_W'(18);
              state <= ST_SPREAD;
            end
          end else begin
            drem <= dge ? CW'(drem_sh - {1'b0, used_count}) : drem_sh[CW-1:0];
            dq   <= dq_next;
            step <= step - STEP_W'(1);
          end
        end
        ST_SPREAD: begin
          unique case (sub)
            2'd0: begin
              lim  <= d * d;
              t_ok <= (t <= {1'b0, d});
              tt   <= t[17:0] * t[17:0];
              sub  <= 2'd1;
            end
            2'd1: begin
              plo <= tt[17:0] * used_count;
              phi <= tt[35:18] * used_count;
              sub <= 2'd2;
            end
            default: begin
              sub <= 2'd0;
              if (step == '0) begin
                step <= STEP_W'(18);
                if (!sel) begin
                  res_spread_mon <= (t_ok && ((prod << 2) <= PW'(lim))) ?
                                    t[MON_W-1:0] : q[MON_W-1:0];
                  d   <= max_ratio - min_ratio;
                  q   <= '0;
                  sel <= 1'b1;
                end else begin
                  if (t_ok && ((prod << 2) <= PW'(lim))) begin
                    q <= t[RATIO_W-1:0];
                  end
                  state <= ST_EMIT;
                end
              end else begin
                if (t_ok && ((prod << 2) <= PW'(lim))) begin
                  q <= t[RATIO_W-1:0];
                end
                step <= step - STEP_W'(1);
              end
            end
          endcase
        end
        default: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            if (used_count == '0) begin
              mean_mon     <= '0;
              mean_ratio   <= '0;
              spread_mon   <= '0;
              spread_ratio <= '0;
              close_stamp  <= '0;
              used_samples <= '0;
              empty_window <= 1'b1;
            end else begin
              mean_mon     <= res_mean_mon;
              mean_ratio   <= res_mean_ratio;
              spread_mon   <= res_spread_mon;
              spread_ratio <= q;
              close_stamp  <= item.stamp;
              used_samples <= (used_ext > (CW+17)'(65535)) ? 16'hFFFF : used_ext[15:0];
              empty_window <= 1'b0;
            end
            sum_mon    <= '0;
            sum_ratio  <= '0;
            used_count <= '0;
            min_mon    <= MON_MAX;
            max_mon    <= '0;
            min_ratio  <= RATIO_MAX;
            max_ratio  <= '0;
            state      <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/windowed_charge_statistics_unit.sv -----
// one sample item per cycle while the four-entry queue has room; back end runs an 18-step
// ratio divide per accumulated item unless the ratio saturates, none if not accumulated
// window close adds 2*(COUNT_WIDTH+18) divide steps and two spread searches; the result
// is registered once any earlier result has been popped
// rst is synchronous, active high: clears the queue, window sums and restores config
// depends on wcs_pkg, wcs_front, wcs_queue, wcs_back
module windowed_charge_statistics_unit
  import wcs_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [MON_W-1:0]      mon_charge,
  input  logic [TOT_W-1:0]      total_charge,
  input  logic [STAMP_W-1:0]    stamp,
  output logic                  empty,
  input  logic                  pop,
  output logic [MON_W-1:0]      mean_mon,
  output logic [RATIO_W-1:0]    mean_ratio,
  output logic [MON_W-1:0]      spread_mon,
  output logic [RATIO_W-1:0]    spread_ratio,
  output logic [STAMP_W-1:0]    close_stamp,
  output logic [15:0]           used_samples,
  output logic                  empty_window
);

  logic  q_wr, q_rd, q_valid;
  item_t wr_item, rd_item;

  wcs_front u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .push, .q_full(full), .mon_charge, .total_charge, .stamp,
    .q_wr, .q_item(wr_item)
  );

  wcs_queue u_queue (
    .clk, .rst, .wr(q_wr), .wr_item, .full, .valid(q_valid),
    .rd(q_rd), .rd_item
  );

  wcs_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_item(rd_item), .q_rd, .empty, .pop,
    .mean_mon, .mean_ratio, .spread_mon, .spread_ratio, .close_stamp,
    .used_samples, .empty_window
  );

`ifndef ASSERT_OFF
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && empty_window) |-> (used_samples == 16'd0 && close_stamp == '0))
    else $error("empty window with nonzero fields");
  a_used_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !empty_window) |-> (used_samples != 16'd0))
    else $error("filled window with zero count");
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");
`endif

endmodule

// ----- tb/tb_windowed_charge_statistics_unit.sv -----
// testbench of windowed_charge_statistics_unit: directed and random sample items
// checked against a cycle-free predictor of the window statistics; needs wcs_pkg
`timescale 1ns / 1ps

module tb_windowed_charge_statistics_unit;
  import wcs_pkg::*;

  localparam int COUNT_W = 16;
  localparam int SETTLE_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [MON_W-1:0]   mean_mon;
    logic [RATIO_W-1:0] mean_ratio;
    logic [MON_W-1:0]   spread_mon;
    logic [RATIO_W-1:0] spread_ratio;
    logic [STAMP_W-1:0] close_stamp;
    logic [15:0]        used_samples;
    logic               empty_window;
  } window_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [MON_W-1:0] mon_charge = '0;
  logic [TOT_W-1:0] total_charge = '0;
  logic [STAMP_W-1:0] stamp = '0;
  logic empty;
  logic pop = 1'b0;
  logic [MON_W-1:0] mean_mon;
  logic [RATIO_W-1:0] mean_ratio;
  logic [MON_W-1:0] spread_mon;
  logic [RATIO_W-1:0] spread_ratio;
  logic [STAMP_W-1:0] close_stamp;
  logic [15:0] used_samples;
  logic empty_window;

  windowed_charge_statistics_unit #(.COUNT_WIDTH(COUNT_W)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .mon_charge(mon_charge), .total_charge(total_charge),
    .stamp(stamp), .empty(empty), .pop(pop),
    .mean_mon(mean_mon), .mean_ratio(mean_ratio), .spread_mon(spread_mon),
    .spread_ratio(spread_ratio), .close_stamp(close_stamp),
    .used_samples(used_samples), .empty_window(empty_window)
  );

  always #2 clk = ~clk;

  // predictor configuration and window state
  logic [15:0] win_len;
  logic [STAMP_W-1:0] t_start;
  logic [MON_W-1:0] lim_low, lim_high;
  logic [TOT_W-1:0] lim_tot;
  logic [15:0] phase;
  logic started;
  logic [COUNT_W+15:0] acc_mon;
  logic [COUNT_W+17:0] acc_ratio;
  logic [COUNT_W-1:0] n_used;
  logic [MON_W-1:0] lo_mon, hi_mon;
  logic [RATIO_W-1:0] lo_ratio, hi_ratio;

  window_stats_t expected_stats[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  function automatic void clear_window();
    acc_mon = '0;
    acc_ratio = '0;
    n_used = '0;
    lo_mon = MON_MAX;
    hi_mon = '0;
    lo_ratio = RATIO_MAX;
    hi_ratio = '0;
  endfunction

  // largest q <= d with 4*q*q*n <= d*d
  function automatic logic [RATIO_W-1:0] spread_of(logic [RATIO_W-1:0] d, longint unsigned n);
    longint unsigned q, t, dd;
    q = 0;
    dd = longint'(d) * longint'(d);
    for (int b = 18; b >= 0; b--) begin
      t = q | (64'd1 << b);
      if (t <= d && 4 * t * t * n <= dd) q = t;
    end
    return q[RATIO_W-1:0];
  endfunction

  function automatic void predict_sample(logic [MON_W-1:0] m, logic [TOT_W-1:0] tc,
                                         logic [STAMP_W-1:0] ts);
    logic closing, pass;
    longint unsigned r;
    logic [RATIO_W-1:0] ratio;
    window_stats_t res;
    closing = started && phase == 0;
    pass = m > lim_low && m < lim_high && ts > t_start;
    phase = (32'(phase) + 1 >= 32'(win_len)) ? 16'd0 : phase + 16'd1;
    started = 1'b1;
    if (!pass) return;
    if (tc < lim_tot && n_used != '1) begin
      r = (longint'(tc) << 16) / longint'(m);
      ratio = (r > RATIO_MAX) ? RATIO_MAX : r[RATIO_W-1:0];
      acc_mon += m;
      acc_ratio += ratio;
      n_used++;
      if (m < lo_mon) lo_mon = m;
      if (m > hi_mon) hi_mon = m;
      if (ratio < lo_ratio) lo_ratio = ratio;
      if (ratio > hi_ratio) hi_ratio = ratio;
    end
    if (closing) begin
      res = '0;
      if (n_used == 0) begin
        res.empty_window = 1'b1;
      end else begin
        res.mean_mon = MON_W'(acc_mon / n_used);
        res.mean_ratio = RATIO_W'(acc_ratio / n_used);
        res.spread_mon = MON_W'(spread_of(RATIO_W'(hi_mon - lo_mon), n_used));
        res.spread_ratio = spread_of(hi_ratio - lo_ratio, n_used);
        res.close_stamp = ts;
        res.used_samples = 16'(n_used);
      end
      expected_stats = {expected_stats, res};
      clear_window();
    end
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    window_stats_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_stats.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          want = expected_stats.pop_front();
          if (mean_mon !== want.mean_mon) report_mismatch("mean_mon", mean_mon, want.mean_mon);
          if (mean_ratio !== want.mean_ratio)
            report_mismatch("mean_ratio", mean_ratio, want.mean_ratio);
          if (spread_mon !== want.spread_mon)
            report_mismatch("spread_mon", spread_mon, want.spread_mon);
          if (spread_ratio !== want.spread_ratio)
            report_mismatch("spread_ratio", spread_ratio, want.spread_ratio);
          if (close_stamp !== want.close_stamp)
            report_mismatch("close_stamp", close_stamp, want.close_stamp);
          if (used_samples !== want.used_samples)
            report_mismatch("used_samples", used_samples, want.used_samples);
          if (empty_window !== want.empty_window)
            report_mismatch("empty_window", empty_window, want.empty_window);
        end
      end
      pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(logic [MON_W-1:0] m, logic [TOT_W-1:0] tc, logic [STAMP_W-1:0] ts);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    mon_charge <= m;
    total_charge <= tc;
    stamp <= ts;
    do @(posedge clk); while (full);
    predict_sample(m, tc, ts);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WINDOW_LENGTH: win_len = value[15:0];
      REG_START_TIME:    t_start = value;
      REG_MON_LOW:       lim_low = value[MON_W-1:0];
      REG_MON_HIGH:      lim_high = value[MON_W-1:0];
      REG_TOT_LIMIT:     lim_tot = value[TOT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(int wl, logic [31:0] ts, int lo, int hi, int tl);
    write_reg(REG_WINDOW_LENGTH, wl);
    write_reg(REG_START_TIME, ts);
    write_reg(REG_MON_LOW, lo);
    write_reg(REG_MON_HIGH, hi);
    write_reg(REG_TOT_LIMIT, tl);
  endtask

  task automatic test_directed();
    set_config(4, 100, 10, 60000, 1000000);
    send_sample(16'd11, 20'd0, 32'd101);
    send_sample(16'd59999, 20'hFFFFF, 32'hFFFFFFFF);
    send_sample(16'd0, 20'd500, 32'd500);
    send_sample(16'hFFFF, 20'd500, 32'd500);
    send_sample(16'd20, 20'd999999, 32'd200);
    // stamps not after start fail the cut
    send_sample(16'd30, 20'd40, 32'd101);
    send_sample(16'd30, 20'd40, 32'd100);
    send_sample(16'd30, 20'd40, 32'd0);
    send_sample(16'd31, 20'd4, 32'd102);
    send_sample(16'd10, 20'd40, 32'd300);
    send_sample(16'd60000, 20'd40, 32'd300);
    send_sample(16'd1234, 20'd77, 32'd300);
    // closing sample passes but its total is too large to accumulate
    send_sample(16'd100, 20'hFFFFF, 32'd400);
    send_sample(16'd5000, 20'd4000, 32'd400);
    send_sample(16'd6000, 20'd8000, 32'd401);
    send_sample(16'd7000, 20'd1000, 32'd402);
    send_sample(16'd7100, 20'd1001, 32'hFFFFFFFF);
    drain();
  endtask

  task automatic test_short_windows();
    set_config(0, 0, 0, 65535, 1048575);
    for (int i = 0; i < 6; i++)
      send_sample(MON_W'($urandom_range(1, 65534)), TOT_W'($urandom),
                  STAMP_W'($urandom_range(1, 9)));
    drain();
    write_reg(REG_WINDOW_LENGTH, 1);
    write_reg(REG_TOT_LIMIT, 0);
    for (int i = 0; i < 4; i++)
      send_sample(MON_W'($urandom_range(1, 65534)), TOT_W'($urandom), 32'd5);
    drain();
  endtask

  task automatic test_length_lowered();
    set_config(10, 0, 0, 65535, 1048575);
    for (int i = 0; i < 7; i++) send_sample(MON_W'(1000 + i), 20'd3000, 32'd7);
    drain();
    write_reg(REG_WINDOW_LENGTH, 3);
    for (int i = 0; i < 8; i++) send_sample(MON_W'(2000 + i), 20'd5000, 32'd8);
    drain();
  endtask

  task automatic test_limits_crossed();
    set_config(2, 0, 100, 101, 1048575);
    for (int i = 0; i < 5; i++) send_sample(MON_W'(100 + i % 2), 20'd10, 32'd9);
    drain();
    set_config(1, 32'hFFFFFFFF, 0, 65535, 1048575);
    for (int i = 0; i < 3; i++) send_sample(16'd500, 20'd10, 32'hFFFFFFFF);
    drain();
  endtask

  task automatic test_random_phase(int idle, int stall, int items, int wl_max);
    int lo, hi;
    logic [MON_W-1:0] m;
    logic [TOT_W-1:0] tc;
    logic [STAMP_W-1:0] ts;
    lo = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4000);
    hi = $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(30000, 65535);
    set_config($urandom_range(1, wl_max), $urandom_range(0, 1000000), lo, hi,
               $urandom_range(0, 2) == 0 ? 1048575 : $urandom_range(1000, 1048575));
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 20) begin
        m = MON_W'($urandom);
        tc = TOT_W'($urandom);
        ts = $urandom;
      end else begin
        m = MON_W'($urandom_range(lo + 1, hi - 1));
        tc = TOT_W'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2 * 32'(m)));
        ts = $urandom_range(t_start + 1, 32'hFFFFFFFF);
      end
      send_sample(m, tc, ts);
    end
    drain();
  endtask

  initial begin
    win_len = RST_WINDOW_LENGTH;
    t_start = RST_START_TIME;
    lim_low = RST_MON_LOW;
    lim_high = RST_MON_HIGH;
    lim_tot = RST_TOT_LIMIT;
    phase = '0;
    started = 1'b0;
    clear_window();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_short_windows();
    test_length_lowered();
    test_limits_crossed();
    test_random_phase(0, 0, 450, 12);
    test_random_phase(51, 0, 450, 8);
    test_random_phase(0, 51, 450, 20);
    test_random_phase(9, 9, 450, 64);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
